### rtl/xfd_pkg.sv
package xfd_pkg;

  // Instruction layouts, in the order the decoder numbers them
  typedef enum logic [3:0] {
    FMT_MODRM_DW   = 4'd0,
    FMT_MODRM      = 4'd1,
    FMT_REG_IMM    = 4'd2,
    FMT_MODRM_SIMM = 4'd3,
    FMT_SHORT_DISP = 4'd4,
    FMT_MODRM_WDSP = 4'd5,
    FMT_MODRM_IMM  = 4'd6,
    FMT_REG_A      = 4'd7,
    FMT_WORD_DISP  = 4'd8,
    FMT_REG_B      = 4'd9,
    FMT_MODRM_V    = 4'd10,
    FMT_MODRM_SEG  = 4'd11,
    FMT_PORT       = 4'd12,
    FMT_ACC_IMM    = 4'd13,
    FMT_W_ONLY     = 4'd14,
    FMT_REG_DISP   = 4'd15
  } fmt_t;

  localparam logic [1:0] MOD_MEM_NODISP = 2'd0;
  localparam logic [1:0] MOD_MEM_DISP8  = 2'd1;
  localparam logic [1:0] MOD_MEM_DISP16 = 2'd2;
  localparam logic [1:0] MOD_REG        = 2'd3;
  localparam logic [2:0] RM_DIRECT      = 3'd6;

  localparam int unsigned IN_DATA_W  = 48;
  localparam int unsigned IN_USER_W  = 4;
  localparam int unsigned RES_W      = 53;
  localparam int unsigned OUT_DATA_W = 56;

  // First member sits in the highest bits; length lands at bit 0
  typedef struct packed {
    logic [7:0]         port_number;
    logic [15:0]        immediate;
    logic signed [15:0] displacement;
    logic [2:0]         rm_field;
    logic [2:0]         reg_field;
    logic [1:0]         mode_field;
    logic               width_bit;
    logic               dir_sign_bit;
    logic [2:0]         length;
  } dec_res_t;

endpackage

### rtl/xfd_decode.sv
module xfd_decode (
  input  xfd_pkg::fmt_t     fmt,
  input  logic [47:0]       bytes,
  output xfd_pkg::dec_res_t res
);

  logic [7:0] b0, b1, b2, b3, b4, b5;
  logic [1:0] modv;
  logic [2:0] rmv;
  logic [2:0] dlen;
  logic signed [15:0] sdisp;
  logic [7:0] imm_lo, imm_hi;
  logic wordimm;

  assign b0 = bytes[7:0];
  assign b1 = bytes[15:8];
  assign b2 = bytes[23:16];
  assign b3 = bytes[31:24];
  assign b4 = bytes[39:32];
  assign b5 = bytes[47:40];
  assign modv = b1[7:6];
  assign rmv  = b1[2:0];

  // Standard ModRM displacement: byte count and value
  always_comb begin
    dlen  = 3'd0;
    sdisp = '0;
    unique case (modv)
      xfd_pkg::MOD_MEM_NODISP: begin
        if (rmv == xfd_pkg::RM_DIRECT) begin
          dlen  = 3'd2;
          sdisp = {b3, b2};
        end
      end
      xfd_pkg::MOD_MEM_DISP8: begin
        dlen  = 3'd1;
        sdisp = {{8{b2[7]}}, b2};
      end
      xfd_pkg::MOD_MEM_DISP16: begin
        dlen  = 3'd2;
        sdisp = {b3, b2};
      end
      default: begin
        dlen  = 3'd0;
        sdisp = '0;
      end
    endcase
  end

  // Immediate follows the displacement
  always_comb begin
    case (dlen)
      3'd1: begin
        imm_lo = b3;
        imm_hi = b4;
      end
      3'd2: begin
        imm_lo = b4;
        imm_hi = b5;
      end
      default: begin
        imm_lo = b2;
        imm_hi = b3;
      end
    endcase
  end

  always_comb begin
    res     = '0;
    wordimm = 1'b0;
    res.length = 3'd1;
    unique case (fmt)
      xfd_pkg::FMT_MODRM_DW, xfd_pkg::FMT_MODRM, xfd_pkg::FMT_MODRM_SEG: begin
        if (fmt == xfd_pkg::FMT_MODRM_DW) begin
          res.dir_sign_bit = b0[1];
          res.width_bit    = b0[0];
        end
        res.mode_field   = modv;
        res.rm_field     = rmv;
        res.reg_field    = (fmt == xfd_pkg::FMT_MODRM_SEG) ? {1'b0, b0[4:3]} : b1[5:3];
        res.displacement = sdisp;
        res.length       = 3'd2 + dlen;
      end
      xfd_pkg::FMT_REG_IMM: begin
        res.width_bit = b0[3];
        res.reg_field = b0[2:0];
        res.immediate = b0[3] ? {b2, b1} : {8'd0, b1};
        res.length    = b0[3] ? 3'd3 : 3'd2;
      end
      xfd_pkg::FMT_MODRM_SIMM, xfd_pkg::FMT_MODRM_IMM: begin
        res.width_bit    = b0[0];
        res.mode_field   = modv;
        res.rm_field     = rmv;
        res.displacement = sdisp;
        if (fmt == xfd_pkg::FMT_MODRM_SIMM) begin
          res.dir_sign_bit = b0[1];
          res.reg_field    = b1[5:3];
          wordimm          = !b0[1] && b0[0];
        end else begin
          wordimm = b0[0];
        end
        res.immediate = wordimm ? {imm_hi, imm_lo} : {8'd0, imm_lo};
        res.length    = 3'd2 + dlen + (wordimm ? 3'd2 : 3'd1);
      end
      xfd_pkg::FMT_SHORT_DISP: begin
        res.length       = 3'd2;
        res.displacement = {{8{b1[7]}}, b1};
      end
      xfd_pkg::FMT_MODRM_WDSP: begin
        res.width_bit  = b0[0];
        res.mode_field = modv;
        res.rm_field   = rmv;
        if (modv == xfd_pkg::MOD_MEM_NODISP) begin
          res.displacement = b0[0] ? {b3, b2} : {{8{b2[7]}}, b2};
          res.length       = b0[0] ? 3'd4 : 3'd3;
        end else if (modv == xfd_pkg::MOD_MEM_DISP8) begin
          res.displacement = {{8{b2[7]}}, b2};
          res.length       = 3'd3;
        end else begin
          res.length = 3'd2;
        end
      end
      xfd_pkg::FMT_REG_A, xfd_pkg::FMT_REG_B: begin
        res.length    = 3'd1;
        res.reg_field = b0[2:0];
      end
      xfd_pkg::FMT_WORD_DISP: begin
        res.length       = 3'd3;
        res.displacement = {b2, b1};
      end
      xfd_pkg::FMT_MODRM_V: begin
        res.length       = 3'd2;
        res.dir_sign_bit = b0[1];
        res.width_bit    = b0[0];
        res.mode_field   = modv;
        res.reg_field    = b1[5:3];
        res.rm_field     = rmv;
      end
      xfd_pkg::FMT_PORT: begin
        res.length      = 3'd2;
        res.width_bit   = b0[0];
        res.port_number = b1;
      end
      xfd_pkg::FMT_ACC_IMM: begin
        res.width_bit = b0[0];
        res.immediate = b0[0] ? {b2, b1} : {8'd0, b1};
        res.length    = b0[0] ? 3'd3 : 3'd2;
      end
      xfd_pkg::FMT_W_ONLY: begin
        res.length    = 3'd1;
        res.width_bit = b0[0];
      end
      default: begin
        // register plus displacement layout
        res.width_bit    = b0[0];
        res.mode_field   = modv;
        res.reg_field    = b1[5:3];
        res.rm_field     = rmv;
        res.displacement = b0[0] ? {b3, b2} : {{8{b2[7]}}, b2};
        res.length       = b0[0] ? 3'd4 : 3'd3;
      end
    endcase
  end

endmodule

### rtl/x86_16_format_field_decoder_unit.sv
// Decodes the fields of one 16-bit x86 instruction per transaction. The format
// number comes in on s_axis_tuser and the first six instruction bytes on
// s_axis_tdata; the length, mode bits, ModRM fields, displacement, immediate and
// port come out packed on m_axis_tdata. The block can take one transaction every
// cycle; each result passes through one input register, the field decode and
// one output register. Both stages hold under back-pressure, so the sustained
// rate is one instruction per cycle whenever the downstream side is ready.
module x86_16_format_field_decoder_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [47:0] s_axis_tdata,  // byte0, byte1, byte2, byte3, byte4, byte5
  input  logic [3:0]  s_axis_tuser,  // req_type
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // length, dir_sign_bit, width_bit, mode_field, reg_field, rm_field,
  // displacement, immediate, port_number, 3 zero pad bits
  output logic [55:0] m_axis_tdata
);

  logic                  in_valid;
  xfd_pkg::fmt_t         in_type;
  logic [47:0]           in_bytes;
  logic                  out_valid;
  xfd_pkg::dec_res_t     out_res;
  xfd_pkg::dec_res_t     dec_res;
  logic                  advance;

  assign advance       = !out_valid || m_axis_tready;
  assign s_axis_tready = !in_valid || advance;

  xfd_decode u_decode (
    .fmt   (in_type),
    .bytes (in_bytes),
    .res   (dec_res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (s_axis_tready) in_valid <= s_axis_tvalid;
      if (advance) out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_type  <= xfd_pkg::fmt_t'(s_axis_tuser);
      in_bytes <= s_axis_tdata;
    end
    if (advance && in_valid) out_res <= dec_res;
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {3'b000, out_res};

endmodule

### rtl/xfd_checker.sv
module xfd_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [55:0] m_axis_tdata
);

  logic [2:0]  len;
  logic [15:0] disp;
  logic [15:0] imm;
  logic [7:0]  port;

  assign len  = m_axis_tdata[2:0];
  assign disp = m_axis_tdata[28:13];
  assign imm  = m_axis_tdata[44:29];
  assign port = m_axis_tdata[52:45];

  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result changed while stalled");

  a_len: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> len != 3'd0 && len != 3'd7 && m_axis_tdata[55:53] == 3'b000)
    else $error("bad length or pad bits");

  a_one_byte: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && len == 3'd1 |-> disp == 16'd0 && imm == 16'd0 && port == 8'd0)
    else $error("one-byte instruction with operand bytes");

  a_port: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && port != 8'd0 |-> len == 3'd2 && disp == 16'd0 && imm == 16'd0)
    else $error("port result with other operands");

  a_drain: assert property (@(posedge clk) disable iff (rst)
    !m_axis_tvalid && !s_axis_tvalid |=> s_axis_tready)
    else $error("input not ready with empty output");

endmodule

bind x86_16_format_field_decoder_unit xfd_checker u_xfd_checker (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

### bench/tb_x86_16_format_field_decoder_unit.sv
`timescale 1ns / 100ps

module tb_x86_16_format_field_decoder_unit;

  localparam int unsigned STALL_LIMIT = 2000;
  localparam int unsigned SETTLE_CYCLES = 8;

  logic        clk;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [47:0] s_axis_tdata = '0;  // byte0, byte1, byte2, byte3, byte4, byte5
  logic [3:0]  s_axis_tuser = '0;  // req_type
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  // length, dir_sign_bit, width_bit, mode_field, reg_field, rm_field,
  // displacement, immediate, port_number, 3 zero pad bits
  logic [55:0] m_axis_tdata;

  xfd_pkg::dec_res_t decoded_fields_q[$];
  int unsigned       mismatch_count = 0;
  int unsigned       stall_cycles = 0;
  bit                full_rate = 1'b0;

  x86_16_format_field_decoder_unit dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic logic [15:0] sext8(input logic [7:0] v);
    return {{8{v[7]}}, v};
  endfunction

  // Displacement after a standard ModRM byte; returns its size in bytes
  function automatic int unsigned modrm_disp(input logic [47:0] raw,
                                             output logic [15:0] d);
    d = '0;
    case (raw[15:14])
      xfd_pkg::MOD_MEM_NODISP: begin
        if (raw[10:8] == xfd_pkg::RM_DIRECT) begin
          d = raw[31:16];
          return 2;
        end
        return 0;
      end
      xfd_pkg::MOD_MEM_DISP8: begin
        d = sext8(raw[23:16]);
        return 1;
      end
      xfd_pkg::MOD_MEM_DISP16: begin
        d = raw[31:16];
        return 2;
      end
      default: return 0;
    endcase
  endfunction

  function automatic xfd_pkg::dec_res_t decode_instr(input xfd_pkg::fmt_t f,
                                                     input logic [47:0] raw);
    xfd_pkg::dec_res_t r;
    logic [15:0]       d;
    int unsigned       dl;
    int unsigned       pos;
    logic              wordimm;
    r = '0;
    r.length = 3'd1;
    case (f)
      xfd_pkg::FMT_MODRM_DW, xfd_pkg::FMT_MODRM, xfd_pkg::FMT_MODRM_SEG: begin
        if (f == xfd_pkg::FMT_MODRM_DW) begin
          r.dir_sign_bit = raw[1];
          r.width_bit = raw[0];
        end
        r.mode_field = raw[15:14];
        r.rm_field = raw[10:8];
        r.reg_field = (f == xfd_pkg::FMT_MODRM_SEG) ? {1'b0, raw[4:3]} : raw[13:11];
        dl = modrm_disp(raw, d);
        r.displacement = d;
        r.length = 3'(2 + dl);
      end
      xfd_pkg::FMT_REG_IMM: begin
        r.width_bit = raw[3];
        r.reg_field = raw[2:0];
        if (raw[3]) begin
          r.immediate = raw[23:8];
          r.length = 3'd3;
        end else begin
          r.immediate = {8'h00, raw[15:8]};
          r.length = 3'd2;
        end
      end
      xfd_pkg::FMT_MODRM_SIMM, xfd_pkg::FMT_MODRM_IMM: begin
        r.width_bit = raw[0];
        r.mode_field = raw[15:14];
        r.rm_field = raw[10:8];
        if (f == xfd_pkg::FMT_MODRM_SIMM) begin
          r.dir_sign_bit = raw[1];
          r.reg_field = raw[13:11];
          wordimm = !raw[1] && raw[0];
        end else begin
          wordimm = raw[0];
        end
        dl = modrm_disp(raw, d);
        r.displacement = d;
        pos = 2 + dl;
        if (wordimm) begin
          r.immediate = raw[8*pos +: 16];
          r.length = 3'(pos + 2);
        end else begin
          r.immediate = {8'h00, raw[8*pos +: 8]};
          r.length = 3'(pos + 1);
        end
      end
      xfd_pkg::FMT_SHORT_DISP: begin
        r.length = 3'd2;
        r.displacement = sext8(raw[15:8]);
      end
      xfd_pkg::FMT_MODRM_WDSP: begin
        r.width_bit = raw[0];
        r.mode_field = raw[15:14];
        r.rm_field = raw[10:8];
        if (raw[15:14] == xfd_pkg::MOD_MEM_NODISP) begin
          if (raw[0]) begin
            r.displacement = raw[31:16];
            r.length = 3'd4;
          end else begin
            r.displacement = sext8(raw[23:16]);
            r.length = 3'd3;
          end
        end else if (raw[15:14] == xfd_pkg::MOD_MEM_DISP8) begin
          r.displacement = sext8(raw[23:16]);
          r.length = 3'd3;
        end else begin
          r.length = 3'd2;
        end
      end
      xfd_pkg::FMT_REG_A, xfd_pkg::FMT_REG_B: begin
        r.reg_field = raw[2:0];
      end
      xfd_pkg::FMT_WORD_DISP: begin
        r.length = 3'd3;
        r.displacement = raw[23:8];
      end
      xfd_pkg::FMT_MODRM_V: begin
        r.length = 3'd2;
        r.dir_sign_bit = raw[1];
        r.width_bit = raw[0];
        r.mode_field = raw[15:14];
        r.reg_field = raw[13:11];
        r.rm_field = raw[10:8];
      end
      xfd_pkg::FMT_PORT: begin
        r.length = 3'd2;
        r.width_bit = raw[0];
        r.port_number = raw[15:8];
      end
      xfd_pkg::FMT_ACC_IMM: begin
        r.width_bit = raw[0];
        if (raw[0]) begin
          r.immediate = raw[23:8];
          r.length = 3'd3;
        end else begin
          r.immediate = {8'h00, raw[15:8]};
          r.length = 3'd2;
        end
      end
      xfd_pkg::FMT_W_ONLY: begin
        r.width_bit = raw[0];
      end
      xfd_pkg::FMT_REG_DISP: begin
        r.width_bit = raw[0];
        r.mode_field = raw[15:14];
        r.reg_field = raw[13:11];
        r.rm_field = raw[10:8];
        if (raw[0]) begin
          r.displacement = raw[31:16];
          r.length = 3'd4;
        end else begin
          r.displacement = sext8(raw[23:16]);
          r.length = 3'd3;
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  function automatic logic [47:0] instr_bytes(input logic [7:0] b0, b1, b2, b3, b4, b5);
    return {b5, b4, b3, b2, b1, b0};
  endfunction

  function automatic logic [47:0] random_bytes();
    logic [47:0] raw;
    raw = 48'({$urandom, $urandom});
    // steer a share of the traffic onto the direct-address form
    if ($urandom_range(3) == 0) begin
      raw[15:14] = xfd_pkg::MOD_MEM_NODISP;
      raw[10:8] = xfd_pkg::RM_DIRECT;
    end
    return raw;
  endfunction

  task automatic send_instr(input xfd_pkg::fmt_t f, input logic [47:0] raw);
    while (!full_rate && $urandom_range(99) < 22) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= raw;
    s_axis_tuser <= f;
    do @(posedge clk); while (!s_axis_tready);
    decoded_fields_q.push_back(decode_instr(f, raw));
  endtask

  task automatic wait_decoded_all();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk); while (decoded_fields_q.size() != 0);
  endtask

  task automatic test_directed();
    send_instr(xfd_pkg::FMT_MODRM_DW,
               instr_bytes(8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00));
    send_instr(xfd_pkg::FMT_MODRM_DW,
               instr_bytes(8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF));
    send_instr(xfd_pkg::FMT_MODRM_DW,
               instr_bytes(8'h03, 8'h06, 8'h34, 8'h12, 8'h00, 8'h00));
    send_instr(xfd_pkg::FMT_MODRM,
               instr_bytes(8'h8B, 8'h45, 8'h80, 8'h55, 8'hAA, 8'h00));
    send_instr(xfd_pkg::FMT_MODRM,
               instr_bytes(8'h8B, 8'h9A, 8'hFF, 8'h7F, 8'h00, 8'h00));
    send_instr(xfd_pkg::FMT_REG_IMM,
               instr_bytes(8'hBF, 8'hCD, 8'hAB, 8'h00, 8'h00, 8'h00));
    send_instr(xfd_pkg::FMT_REG_IMM,
               instr_bytes(8'hB0, 8'hFF, 8'hEE, 8'h00, 8'h00, 8'h00));
    // word immediate behind a direct address: reaches the last two bytes
    send_instr(xfd_pkg::FMT_MODRM_SIMM,
               instr_bytes(8'h81, 8'h06, 8'h11, 8'h22, 8'h33, 8'h44));
    send_instr(xfd_pkg::FMT_MODRM_SIMM,
               instr_bytes(8'h83, 8'h40, 8'hF0, 8'h99, 8'h00, 8'h00));
    send_instr(xfd_pkg::FMT_MODRM_SIMM,
               instr_bytes(8'h80, 8'hC0, 8'h7F, 8'h12, 8'h00, 8'h00));
    send_instr(xfd_pkg::FMT_SHORT_DISP,
               instr_bytes(8'hEB, 8'h80, 8'h00, 8'h00, 8'h00, 8'h00));
    send_instr(xfd_pkg::FMT_MODRM_WDSP,
               instr_bytes(8'hA1, 8'h00, 8'hFF, 8'hFF, 8'h00, 8'h00));
    send_instr(xfd_pkg::FMT_MODRM_WDSP,
               instr_bytes(8'hA0, 8'h07, 8'h80, 8'h00, 8'h00, 8'h00));
    send_instr(xfd_pkg::FMT_MODRM_WDSP,
               instr_bytes(8'hA1, 8'h40, 8'h01, 8'h00, 8'h00, 8'h00));
    send_instr(xfd_pkg::FMT_MODRM_WDSP,
               instr_bytes(8'hA1, 8'hBF, 8'h01, 8'h02, 8'h00, 8'h00));
    send_instr(xfd_pkg::FMT_MODRM_IMM,
               instr_bytes(8'hC7, 8'h80, 8'h00, 8'h80, 8'hFE, 8'hCA));
    send_instr(xfd_pkg::FMT_MODRM_IMM,
               instr_bytes(8'hC6, 8'h05, 8'hEE, 8'h00, 8'h00, 8'h00));
    send_instr(xfd_pkg::FMT_REG_A,
               instr_bytes(8'h47, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF));
    send_instr(xfd_pkg::FMT_REG_B,
               instr_bytes(8'h97, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00));
    send_instr(xfd_pkg::FMT_WORD_DISP,
               instr_bytes(8'hE8, 8'h00, 8'h80, 8'h00, 8'h00, 8'h00));
    send_instr(xfd_pkg::FMT_MODRM_V,
               instr_bytes(8'hD3, 8'hE8, 8'h55, 8'h00, 8'h00, 8'h00));
    send_instr(xfd_pkg::FMT_MODRM_SEG,
               instr_bytes(8'h8E, 8'h18, 8'h00, 8'h00, 8'h00, 8'h00));
    send_instr(xfd_pkg::FMT_PORT,
               instr_bytes(8'hE5, 8'hFF, 8'h00, 8'h00, 8'h00, 8'h00));
    send_instr(xfd_pkg::FMT_ACC_IMM,
               instr_bytes(8'h05, 8'h34, 8'h12, 8'h00, 8'h00, 8'h00));
    send_instr(xfd_pkg::FMT_W_ONLY,
               instr_bytes(8'hA5, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00));
    send_instr(xfd_pkg::FMT_REG_DISP,
               instr_bytes(8'h88, 8'h47, 8'h80, 8'h00, 8'h00, 8'h00));
  endtask

  task automatic test_random_mix(input int unsigned count);
    repeat (count) send_instr(xfd_pkg::fmt_t'($urandom_range(15)), random_bytes());
  endtask

  // sender holds off until every decoded instruction has come back
  task automatic test_drain_pause();
    repeat (10) begin
      repeat ($urandom_range(40, 5)) begin
        send_instr(xfd_pkg::fmt_t'($urandom_range(15)), random_bytes());
      end
      wait_decoded_all();
    end
  endtask

  task automatic test_full_rate();
    full_rate = 1'b1;
    repeat (400) send_instr(xfd_pkg::fmt_t'($urandom_range(15)), random_bytes());
    full_rate = 1'b0;
  endtask

  always @(posedge clk) begin
    m_axis_tready <= full_rate || ($urandom_range(99) >= 22);
  end

  task automatic check_field(input string name, input int unsigned expv, input int unsigned actv);
    if (expv != actv) begin
      $error("%s: expected 0x%0h, actual 0x%0h", name, expv, actv);
      mismatch_count++;
    end
  endtask

  always @(posedge clk) begin
    xfd_pkg::dec_res_t expf;
    xfd_pkg::dec_res_t actf;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      actf = xfd_pkg::dec_res_t'(m_axis_tdata[52:0]);
      if (decoded_fields_q.size() == 0) begin
        $error("result transaction with nothing pending: 0x%0h", m_axis_tdata);
        mismatch_count++;
      end else begin
        expf = decoded_fields_q.pop_front();
        check_field("length", 32'(expf.length), 32'(actf.length));
        check_field("dir_sign_bit", 32'(expf.dir_sign_bit), 32'(actf.dir_sign_bit));
        check_field("width_bit", 32'(expf.width_bit), 32'(actf.width_bit));
        check_field("mode_field", 32'(expf.mode_field), 32'(actf.mode_field));
        check_field("reg_field", 32'(expf.reg_field), 32'(actf.reg_field));
        check_field("rm_field", 32'(expf.rm_field), 32'(actf.rm_field));
        check_field("displacement", 32'($unsigned(expf.displacement)),
                    32'($unsigned(actf.displacement)));
        check_field("immediate", 32'(expf.immediate), 32'(actf.immediate));
        check_field("port_number", 32'(expf.port_number), 32'(actf.port_number));
      end
    end
  end

  // watchdog: cycles with no transaction on either side
  always @(posedge clk) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_random_mix(700);
    test_drain_pause();
    test_full_rate();
    test_random_mix(500);
    wait_decoded_all();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && decoded_fields_q.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
